[src/ddpc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the differential-drive pose controller.
// No dependencies; every other file imports this package.
package ddpc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int POSE_WIDTH    = 32;
  localparam int ATAN_LEN      = 24;
  localparam int CORDIC_ITERS  = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int ITER_W        = $clog2(CORDIC_ITERS);

  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int WIDE_W  = 67;
  localparam int DVD_W   = 62;
  localparam int DVS_W   = 38;
  localparam int DCNT_W  = $clog2(DVD_W);
  localparam int CS_W    = 33;
  localparam int ANG_W   = 32;
  localparam int IDX_W   = 3;

  localparam logic signed [33:0]      FULL_TURN    = 34'sd23592960;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 32'sd11796480;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 32'sd5898240;
  localparam int CORDIC_GAIN = 652032874;
  localparam int PI_Q20      = 3294199;
  localparam int HEAD_SCALE  = 720;   // 180 degrees times the Q2.14 to Q16.16 factor of 4

  // one turn is 45 * 2^19 in Q16.16 degrees: reduce the upper part by 45 with a reciprocal
  localparam int RED_W       = 40;
  localparam int TURN_SHIFT  = 19;
  localparam int TURN_UNITS  = 45;
  localparam int RECIP_TURN  = 95443718;   // ceil(2^32 / 45)

  typedef enum logic [IDX_W-1:0] {
    REG_REF_X        = 3'd0,
    REG_REF_Y        = 3'd1,
    REG_REF_HEADING  = 3'd2,
    REG_WHEEL_BASE   = 3'd3,
    REG_WHEEL_RADIUS = 3'd4,
    REG_GAIN_X       = 3'd5,
    REG_GAIN_HEADING = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_M_TRAV, ST_M_DIFF, ST_M_NUM, ST_M_DEN,
    ST_DIV1_GO, ST_DIV1_WAIT, ST_HEAD_RED, ST_HEAD_TAKE,
    ST_COS1_GO, ST_COS1_WAIT, ST_PX, ST_PY, ST_EX, ST_EY, ST_FWD,
    ST_V, ST_V_TAKE, ST_SIN2_GO, ST_SIN2_WAIT, ST_W, ST_LW, ST_LW_TAKE,
    ST_DIVR_GO, ST_DIVR_WAIT, ST_DIVL_WAIT
  } ctrl_state_t;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-32:0] hi;
    hi = v[WIDE_W-1:31];
    if ((&hi) || !(|hi)) return v[31:0];
    else if (v[WIDE_W-1]) return {1'b1, {31{1'b0}}};
    else return {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic signed [POSE_WIDTH-1:0] sat_pose(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-POSE_WIDTH:0] hi;
    hi = v[WIDE_W-1:POSE_WIDTH-1];
    if ((&hi) || !(|hi)) return v[POSE_WIDTH-1:0];
    else if (v[WIDE_W-1]) return {1'b1, {(POSE_WIDTH-1){1'b0}}};
    else return {1'b0, {(POSE_WIDTH-1){1'b1}}};
  endfunction

  // fold an angle within one and a half turns into [-180, 180) degrees
  function automatic logic signed [ANG_W-1:0] wrap_turn(input logic signed [33:0] s);
    logic signed [33:0] r;
    if (s >= 34'(HALF_TURN)) r = s - FULL_TURN;
    else if (s < -34'(HALF_TURN)) r = s + FULL_TURN;
    else r = s;
    return r[ANG_W-1:0];
  endfunction

endpackage

[src/ddpc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: wheel step input, command output, register write.
// Depends on ddpc_pkg for widths.
interface ddpc_in_if import ddpc_pkg::*;;
  logic               valid;
  logic               ready;
  logic signed [15:0] right_angle_step;
  logic signed [15:0] left_angle_step;
  modport source (output valid, right_angle_step, left_angle_step, input ready);
  modport sink   (input valid, right_angle_step, left_angle_step, output ready);
endinterface

interface ddpc_out_if import ddpc_pkg::*;;
  logic               valid;
  logic               ready;
  logic signed [31:0] linear_command;
  logic signed [31:0] angular_command;
  logic signed [31:0] right_wheel_speed;
  logic signed [31:0] left_wheel_speed;
  modport source (output valid, linear_command, angular_command, right_wheel_speed,
                  left_wheel_speed, input ready);
  modport sink   (input valid, linear_command, angular_command, right_wheel_speed,
                  left_wheel_speed, output ready);
endinterface

interface ddpc_cfg_if import ddpc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [31:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/ddpc_mul.sv]
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on ddpc_pkg.
module ddpc_mul import ddpc_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

[src/ddpc_div.sv]
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle while busy.
// Depends on ddpc_pkg.
module ddpc_div import ddpc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  logic              busy_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DVD_W - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

[src/ddpc_cordic.sv]
`timescale 1ns / 1ps
// Iterative rotation CORDIC: cosine and sine in Q30 of a Q16.16 degree angle.
// Depends on ddpc_pkg (stage count, arctangent table, gain).
module ddpc_cordic import ddpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ANG_W-1:0] angle,
  output logic                    busy,
  output logic signed [CS_W-1:0]  cos_q,
  output logic signed [CS_W-1:0]  sin_q
);

  logic                    busy_r;
  logic [ITER_W-1:0]       iter_r;
  logic signed [CS_W-1:0]  x_r, y_r;
  logic signed [ANG_W-1:0] z_r;
  logic                    flip_r;
  logic signed [ANG_W-1:0] z_init;
  logic                    flip_init;
  logic signed [CS_W-1:0]  x_sh, y_sh;
  logic signed [ANG_W-1:0] step_ang;

  // fold into [-90, 90] with a sign flip on the result
  always_comb begin
    if (angle > QUARTER_TURN) begin
      z_init    = angle - HALF_TURN;
      flip_init = 1'b1;
    end else if (angle < -QUARTER_TURN) begin
      z_init    = angle + HALF_TURN;
      flip_init = 1'b1;
    end else begin
      z_init    = angle;
      flip_init = 1'b0;
    end
  end

  assign x_sh     = x_r >>> iter_r;
  assign y_sh     = y_r >>> iter_r;
  assign step_ang = ANG_W'(atan_deg(5'(iter_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      iter_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      iter_r <= '0;
    end else if (busy_r) begin
      iter_r <= iter_r + 1'b1;
      if (iter_r == ITER_W'(CORDIC_ITERS - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CS_W'(CORDIC_GAIN);
      y_r    <= '0;
      z_r    <= z_init;
      flip_r <= flip_init;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - step_ang;
      end else begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + step_ang;
      end
    end
  end

  assign busy  = busy_r;
  assign cos_q = flip_r ? -x_r : x_r;
  assign sin_q = flip_r ? -y_r : y_r;

endmodule

[src/diff_drive_pose_controller.sv]
`timescale 1ns / 1ps
// Differential-drive odometry and pose controller, top level.
// Depends on ddpc_pkg, ddpc_if, ddpc_mul, ddpc_div and ddpc_cordic.
//
// One transfer on in_ch is one control tick: the two wheel angle steps (Q2.14 rad)
// advance the dead-reckoned pose (x, y in Q16.16 mm, heading in Q16.16 degrees
// kept in [-180, 180)), and one transfer on out_ch returns v, w and the two wheel
// speeds, all Q16.16 and saturated. A tick makes three passes through the shared
// one-bit-per-cycle divider (heading step and the two wheel speeds), two passes of
// the iterative CORDIC and a chain of steps around the shared 33x33 multiplier.
// Angles are folded into one turn by a reciprocal multiply on that multiplier.
// in_ch.ready is high only while the sequencer is idle, so the next tick is taken
// in the cycle after a result is loaded at the earliest; a finished result sits in
// the output register, so the next tick may be taken while it waits, and the
// sequencer holds at its last step only if the previous result is still untaken.
// Register writes on cfg_ch are always taken and must arrive while no tick is in
// flight. Wheel base or radius of zero act as one.
module diff_drive_pose_controller import ddpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ddpc_in_if.sink    in_ch,
  ddpc_out_if.source out_ch,
  ddpc_cfg_if.sink   cfg_ch
);

  // configuration registers
  logic signed [31:0] ref_x_r, ref_y_r, ref_heading_r;
  logic [15:0]        wheel_base_r, wheel_radius_r;
  logic [7:0]         gain_x_r, gain_heading_r;

  // pose state
  logic signed [POSE_WIDTH-1:0] pose_x_r, pose_y_r;
  logic signed [ANG_W-1:0]      pose_heading_r;

  // working registers of one tick
  ctrl_state_t              state_r, state_nxt;
  logic signed [15:0]       ra_r, la_r;
  logic signed [31:0]       travel_r;
  logic [41:0]              num_mag_r;
  logic                     num_neg_r;
  logic                     hsign_r;
  logic [RED_W-1:0]         red_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [32:0]       fwd_r;
  logic signed [31:0]       v_r, w_r, rs_r;
  logic signed [48:0]       lw_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_lin_r, out_ang_r, out_rs_r, out_ls_r;

  // shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     div_start, div_busy;
  logic [DVD_W-1:0]         div_dvd, div_quo;
  logic [DVS_W-1:0]         div_dvs;
  logic                     cor_start, cor_busy;
  logic signed [ANG_W-1:0]  cor_angle;
  logic signed [CS_W-1:0]   cor_cos, cor_sin;

  // combinational datapath
  logic [15:0]              rad_eff, base_eff;
  logic signed [16:0]       rad_s, base_s;
  logic signed [16:0]       ang_sum, ang_diff;
  logic [PROD_W-1:0]        prod_abs;
  logic signed [WIDE_W-1:0] prod_w;
  logic signed [31:0]       ex, ey;
  logic signed [WIDE_W-1:0] fwd_sum, fwd_sh;
  logic [15:0]              red_q;
  logic [21:0]              red_q45, red_m45;
  logic [24:0]              red_rem;
  logic signed [33:0]       rem_s;
  logic signed [33:0]       ref_diff;
  logic [33:0]              ref_abs;
  logic signed [ANG_W-1:0]  head_new, err_angle;
  logic signed [32:0]       v2;
  logic signed [49:0]       numer_p, numer_m;
  logic [49:0]              numer_p_abs, numer_m_abs;
  logic signed [WIDE_W-1:0] q_w, q_s;
  logic                     out_free;

  assign rad_eff  = (wheel_radius_r == '0) ? 16'd1 : wheel_radius_r;
  assign base_eff = (wheel_base_r == '0) ? 16'd1 : wheel_base_r;
  assign rad_s    = signed'({1'b0, rad_eff});
  assign base_s   = signed'({1'b0, base_eff});
  assign ang_sum  = 17'(ra_r) + 17'(la_r);
  assign ang_diff = 17'(ra_r) - 17'(la_r);

  assign prod_w   = WIDE_W'(mul_p);
  assign prod_abs = mul_p[PROD_W-1] ? -mul_p : mul_p;

  assign ex = sat32(WIDE_W'(ref_x_r) - WIDE_W'(pose_x_r));
  assign ey = sat32(WIDE_W'(ref_y_r) - WIDE_W'(pose_y_r));

  assign fwd_sum = WIDE_W'(acc_r) + prod_w;
  assign fwd_sh  = fwd_sum >>> 30;

  // magnitude modulo one turn: the product holds the upper part divided by 45
  assign red_q   = mul_p[47:32];
  assign red_q45 = 22'(red_q) * 22'(TURN_UNITS);
  assign red_m45 = 22'(red_r[RED_W-1:TURN_SHIFT]) - red_q45;
  assign red_rem = {red_m45[5:0], red_r[TURN_SHIFT-1:0]};

  // signed remainder of the last reduction, then fold into one turn
  assign rem_s     = hsign_r ? -signed'(34'(red_rem)) : signed'(34'(red_rem));
  assign head_new  = wrap_turn(34'(pose_heading_r) + rem_s);
  assign err_angle = wrap_turn(rem_s);

  assign ref_diff = 34'(ref_heading_r) - 34'(pose_heading_r);
  assign ref_abs  = ref_diff[33] ? -ref_diff : ref_diff;

  assign v2          = {v_r, 1'b0};
  assign numer_p     = 50'(v2) + 50'(lw_r);
  assign numer_m     = 50'(v2) - 50'(lw_r);
  assign numer_p_abs = numer_p[49] ? -numer_p : numer_p;
  assign numer_m_abs = numer_m[49] ? -numer_m : numer_m;

  assign q_w = signed'(WIDE_W'(div_quo));
  assign q_s = hsign_r ? -q_w : q_w;

  assign out_free = !out_valid_r || out_ch.ready;

  ddpc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  ddpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (div_quo)
  );

  ddpc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .busy  (cor_busy),
    .cos_q (cor_cos),
    .sin_q (cor_sin)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // next state and unit controls
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    cor_start = 1'b0;
    cor_angle = pose_heading_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_M_TRAV;
      end
      ST_M_TRAV: begin
        mul_a     = MUL_W'(ang_sum);
        mul_b     = MUL_W'(rad_s);
        state_nxt = ST_M_DIFF;
      end
      ST_M_DIFF: begin
        mul_a     = MUL_W'(ang_diff);
        mul_b     = MUL_W'(HEAD_SCALE);
        state_nxt = ST_M_NUM;
      end
      ST_M_NUM: begin
        mul_a     = signed'(mul_p[MUL_W-1:0]);
        mul_b     = MUL_W'(rad_s);
        state_nxt = ST_M_DEN;
      end
      ST_M_DEN: begin
        mul_a     = MUL_W'(base_s);
        mul_b     = MUL_W'(PI_Q20);
        state_nxt = ST_DIV1_GO;
      end
      ST_DIV1_GO: begin
        div_start = 1'b1;
        div_dvd   = {num_mag_r, 20'b0};
        div_dvs   = mul_p[DVS_W-1:0];
        state_nxt = ST_DIV1_WAIT;
      end
      ST_DIV1_WAIT: begin
        if (!div_busy) state_nxt = ST_HEAD_RED;
      end
      ST_HEAD_RED: begin
        mul_a     = MUL_W'(red_r[RED_W-1:TURN_SHIFT]);
        mul_b     = MUL_W'(RECIP_TURN);
        state_nxt = ST_HEAD_TAKE;
      end
      ST_HEAD_TAKE: begin
        state_nxt = ST_COS1_GO;
      end
      ST_COS1_GO: begin
        cor_start = 1'b1;
        cor_angle = pose_heading_r;
        state_nxt = ST_COS1_WAIT;
      end
      ST_COS1_WAIT: begin
        mul_a = MUL_W'(travel_r);
        mul_b = cor_cos;
        if (!cor_busy) state_nxt = ST_PX;
      end
      ST_PX: begin
        mul_a     = MUL_W'(travel_r);
        mul_b     = cor_sin;
        state_nxt = ST_PY;
      end
      ST_PY: begin
        state_nxt = ST_EX;
      end
      ST_EX: begin
        mul_a     = cor_cos;
        mul_b     = MUL_W'(ex);
        state_nxt = ST_EY;
      end
      ST_EY: begin
        mul_a     = cor_sin;
        mul_b     = MUL_W'(ey);
        state_nxt = ST_FWD;
      end
      ST_FWD: begin
        state_nxt = ST_V;
      end
      ST_V: begin
        mul_a     = fwd_r;
        mul_b     = MUL_W'(gain_x_r);
        state_nxt = ST_V_TAKE;
      end
      ST_V_TAKE: begin
        mul_a     = MUL_W'(red_r[RED_W-1:TURN_SHIFT]);
        mul_b     = MUL_W'(RECIP_TURN);
        state_nxt = ST_SIN2_GO;
      end
      ST_SIN2_GO: begin
        cor_start = 1'b1;
        cor_angle = err_angle;
        state_nxt = ST_SIN2_WAIT;
      end
      ST_SIN2_WAIT: begin
        mul_a = MUL_W'(gain_heading_r);
        mul_b = cor_sin;
        if (!cor_busy) state_nxt = ST_W;
      end
      ST_W: begin
        state_nxt = ST_LW;
      end
      ST_LW: begin
        mul_a     = MUL_W'(w_r);
        mul_b     = MUL_W'(base_s);
        state_nxt = ST_LW_TAKE;
      end
      ST_LW_TAKE: begin
        state_nxt = ST_DIVR_GO;
      end
      ST_DIVR_GO: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(numer_p_abs);
        div_dvs   = DVS_W'({rad_eff, 1'b0});
        state_nxt = ST_DIVR_WAIT;
      end
      ST_DIVR_WAIT: begin
        if (!div_busy) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(numer_m_abs);
          div_dvs   = DVS_W'({rad_eff, 1'b0});
          state_nxt = ST_DIVL_WAIT;
        end
      end
      ST_DIVL_WAIT: begin
        // hold here until the output register is free
        if (!div_busy && out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r        <= '0;
      ref_y_r        <= '0;
      ref_heading_r  <= '0;
      wheel_base_r   <= 16'd1;
      wheel_radius_r <= 16'd1;
      gain_x_r       <= 8'd20;
      gain_heading_r <= 8'd5;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_REF_X:        ref_x_r        <= cfg_ch.data;
        REG_REF_Y:        ref_y_r        <= cfg_ch.data;
        REG_REF_HEADING:  ref_heading_r  <= cfg_ch.data;
        REG_WHEEL_BASE:   wheel_base_r   <= cfg_ch.data[15:0];
        REG_WHEEL_RADIUS: wheel_radius_r <= cfg_ch.data[15:0];
        REG_GAIN_X:       gain_x_r       <= cfg_ch.data[7:0];
        REG_GAIN_HEADING: gain_heading_r <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  // pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r       <= '0;
      pose_y_r       <= '0;
      pose_heading_r <= '0;
    end else begin
      if (state_r == ST_HEAD_TAKE) pose_heading_r <= head_new;
      if (state_r == ST_PX) pose_x_r <= sat_pose(WIDE_W'(pose_x_r) + (prod_w >>> 30));
      if (state_r == ST_PY) pose_y_r <= sat_pose(WIDE_W'(pose_y_r) + (prod_w >>> 30));
    end
  end

  // per-tick working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ra_r <= in_ch.right_angle_step;
        la_r <= in_ch.left_angle_step;
      end
      ST_M_DIFF: travel_r <= sat32(prod_w <<< 1);
      ST_M_DEN: begin
        num_mag_r <= prod_abs[41:0];
        num_neg_r <= mul_p[PROD_W-1];
      end
      ST_DIV1_GO: hsign_r <= num_neg_r;
      ST_DIV1_WAIT: begin
        if (!div_busy) red_r <= div_quo[RED_W-1:0];
      end
      ST_EY:      acc_r   <= mul_p;
      ST_FWD: begin
        fwd_r   <= fwd_sh[32:0];
        hsign_r <= ref_diff[33];
        red_r   <= RED_W'(ref_abs);
      end
      ST_V_TAKE: v_r  <= sat32(prod_w);
      ST_W:      w_r  <= sat32(prod_w >>> 14);
      ST_LW_TAKE: lw_r <= mul_p[48:0];
      ST_DIVR_GO: hsign_r <= numer_p[49];
      ST_DIVR_WAIT: begin
        if (!div_busy) begin
          rs_r    <= sat32(q_s);
          hsign_r <= numer_m[49];
        end
      end
      default: ;
    endcase
  end

  // output register: load at the end of a tick, drop valid on the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DIVL_WAIT && !div_busy && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIVL_WAIT && !div_busy && out_free) begin
      out_lin_r <= v_r;
      out_ang_r <= w_r;
      out_rs_r  <= rs_r;
      out_ls_r  <= sat32(q_s);
    end
  end

  assign in_ch.ready              = (state_r == ST_IDLE);
  assign cfg_ch.ready             = 1'b1;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.linear_command    = out_lin_r;
  assign out_ch.angular_command   = out_ang_r;
  assign out_ch.right_wheel_speed = out_rs_r;
  assign out_ch.left_wheel_speed  = out_ls_r;

  // the stored heading always stays within one turn
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pose_heading_r >= -HALF_TURN) && (pose_heading_r < HALF_TURN))
    else $error("pose heading left [-180, 180)");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_cordic_free: assert property (@(posedge clk) disable iff (!rst_n)
    cor_start |-> !cor_busy)
    else $error("CORDIC started while busy");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVL_WAIT && state_nxt == ST_IDLE) |=> out_valid_r)
    else $error("tick finished without a result");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for diff_drive_pose_controller: predicts each wheel command
// from its own odometry and CORDIC model. Depends on ddpc_pkg, ddpc_if and the RTL.
module testbench;
  import ddpc_pkg::*;

  typedef struct packed {
    logic signed [15:0] right_step;
    logic signed [15:0] left_step;
  } wheel_step_t;

  typedef struct packed {
    logic signed [31:0] linear;
    logic signed [31:0] angular;
    logic signed [31:0] right_speed;
    logic signed [31:0] left_speed;
  } wheel_cmd_t;

  localparam logic [IDX_W-1:0] UNUSED_REG = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ddpc_in_if  in_ch();
  ddpc_out_if out_ch();
  ddpc_cfg_if cfg_ch();

  diff_drive_pose_controller dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow registers and pose of the predictor
  longint tgt_x, tgt_y, tgt_heading;
  longint base_mm, radius_mm, k_fwd, k_head;
  longint odo_x, odo_y, odo_heading;

  wheel_step_t pending_steps[$];
  wheel_cmd_t  expected_cmds[$];
  int          error_count = 0;
  bit          quiet = 1'b0;     // no idling on either side
  int          hold_off = 0;     // long receiver stall, counted by the sink process

  longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint clamp_bits(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint fold_turn(longint a);
    longint m;
    m = a % (360 * 65536);
    if (m >= 180 * 65536) m -= 360 * 65536;
    if (m < -180 * 65536) m += 360 * 65536;
    return m;
  endfunction

  // rotation CORDIC, Q30 cosine and sine of a Q16.16 degree angle
  task automatic cordic_deg(input longint angle, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = fold_turn(angle);
    x = CORDIC_GAIN;
    y = 0;
    flip = 1'b0;
    if (z > 90 * 65536) begin
      z -= 180 * 65536;
      flip = 1'b1;
    end else if (z < -90 * 65536) begin
      z += 180 * 65536;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // advance the pose by one tick and form the wheel command
  task automatic odometry_step(input wheel_step_t st, output wheel_cmd_t cmd);
    longint rad, bas, rarc, larc, travel, dhead, c, s, ex, ey, v, w, lw;
    rad = (radius_mm == 0) ? 1 : radius_mm;
    bas = (base_mm == 0) ? 1 : base_mm;
    rarc = longint'(st.right_step) * rad * 4;
    larc = longint'(st.left_step) * rad * 4;
    travel = clamp_bits((rarc + larc) / 2, 32);
    dhead = ((rarc - larc) * 180 * 1048576) / (bas * PI_Q20);
    odo_heading = fold_turn(odo_heading + fold_turn(dhead));
    cordic_deg(odo_heading, c, s);
    odo_x = clamp_bits(odo_x + ((travel * c) >>> 30), POSE_WIDTH);
    odo_y = clamp_bits(odo_y + ((travel * s) >>> 30), POSE_WIDTH);
    ex = clamp_bits(tgt_x - odo_x, 32);
    ey = clamp_bits(tgt_y - odo_y, 32);
    v = clamp_bits(k_fwd * ((c * ex + s * ey) >>> 30), 32);
    cordic_deg(tgt_heading - odo_heading, c, s);
    w = clamp_bits((k_head * s) >>> 14, 32);
    lw = w * bas;
    cmd.linear = v[31:0];
    cmd.angular = w[31:0];
    cmd.right_speed = 32'(clamp_bits((2 * v + lw) / (2 * rad), 32));
    cmd.left_speed = 32'(clamp_bits((2 * v - lw) / (2 * rad), 32));
  endtask

  // Driver: offer queued steps, insert random gaps, predict on each transfer.
  int in_gap = 0;
  always @(posedge clk) begin
    wheel_cmd_t cmd;
    bit fire;
    fire = in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (fire) begin
        odometry_step(pending_steps[0], cmd);
        expected_cmds.push_back(cmd);
        void'(pending_steps.pop_front());
      end
      // hold an offer that was not taken
      if (!(in_ch.valid && !fire)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 6);
          in_ch.valid <= 1'b0;
        end else if (pending_steps.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.right_angle_step <= pending_steps[0].right_step;
          in_ch.left_angle_step <= pending_steps[0].left_step;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the output at random, compare each transfer with the oldest prediction.
  int out_gap = 0;
  always @(posedge clk) begin
    wheel_cmd_t exp_cmd;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected command transfer");
        error_count++;
      end else begin
        exp_cmd = expected_cmds.pop_front();
        if (out_ch.linear_command !== exp_cmd.linear) begin
          $error("linear_command: expected %0d, got %0d", exp_cmd.linear,
                 out_ch.linear_command);
          error_count++;
        end
        if (out_ch.angular_command !== exp_cmd.angular) begin
          $error("angular_command: expected %0d, got %0d", exp_cmd.angular,
                 out_ch.angular_command);
          error_count++;
        end
        if (out_ch.right_wheel_speed !== exp_cmd.right_speed) begin
          $error("right_wheel_speed: expected %0d, got %0d", exp_cmd.right_speed,
                 out_ch.right_wheel_speed);
          error_count++;
        end
        if (out_ch.left_wheel_speed !== exp_cmd.left_speed) begin
          $error("left_wheel_speed: expected %0d, got %0d", exp_cmd.left_speed,
                 out_ch.left_wheel_speed);
          error_count++;
        end
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // write one register and mirror it into the predictor
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_REF_X:        tgt_x = longint'(signed'(val));
      REG_REF_Y:        tgt_y = longint'(signed'(val));
      REG_REF_HEADING:  tgt_heading = longint'(signed'(val));
      REG_WHEEL_BASE:   base_mm = val[15:0];
      REG_WHEEL_RADIUS: radius_mm = val[15:0];
      REG_GAIN_X:       k_fwd = val[7:0];
      REG_GAIN_HEADING: k_head = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] rx, ry, rh, input logic [31:0] wb, wr,
                           input logic [31:0] gx, gh);
    write_reg(REG_REF_X, rx);
    write_reg(REG_REF_Y, ry);
    write_reg(REG_REF_HEADING, rh);
    write_reg(REG_WHEEL_BASE, wb);
    write_reg(REG_WHEEL_RADIUS, wr);
    write_reg(REG_GAIN_X, gx);
    write_reg(REG_GAIN_HEADING, gh);
  endtask

  task automatic push_step(input logic [15:0] r, input logic [15:0] l);
    wheel_step_t st;
    st.right_step = r;
    st.left_step = l;
    pending_steps.push_back(st);
  endtask

  // drain: let every step be taken and every command come back, then settle
  task automatic drain();
    while (pending_steps.size() > 0 || expected_cmds.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random steps: mostly small, plausible wheel motion, some full-range noise
  task automatic push_random(input int count);
    logic [15:0] r, l;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          r = $urandom;
          l = $urandom;
        end
        2: begin
          r = $urandom;
          l = r;
        end
        default: begin
          r = 16'($signed($urandom_range(0, 4000)) - 2000);
          l = 16'($signed(r) + $signed($urandom_range(0, 400)) - 200);
        end
      endcase
      push_step(r, l);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.right_angle_step = '0;
    in_ch.left_angle_step = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    tgt_x = 0; tgt_y = 0; tgt_heading = 0;
    base_mm = 1; radius_mm = 1; k_fwd = 20; k_head = 5;
    odo_x = 0; odo_y = 0; odo_heading = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed steps at reset settings: extremes, straight runs, spins
    push_step(16'sd0, 16'sd0);
    push_step(16'sd32767, 16'sd32767);
    push_step(-16'sd32768, -16'sd32768);
    push_step(16'sd32767, -16'sd32768);
    push_step(-16'sd32768, 16'sd32767);
    push_step(16'sd1, -16'sd1);
    push_step(16'sd16384, 16'sd16384);
    drain();

    // extremes of the registers: zero base and radius act as one, unknown index dropped
    write_all(32'h7fff_ffff, 32'h8000_0000, 32'h00b4_0000, 32'hffff_0000,
              32'hffff_0000, 32'h0000_00ff, 32'h0000_0000);
    write_reg(UNUSED_REG, 32'hffff_ffff);
    push_step(16'sd32767, 16'sd32767);
    push_step(-16'sd32768, 16'sd32767);
    push_step(16'sd100, -16'sd100);
    push_step(16'sd0, 16'sd0);
    drain();
    write_all(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_ffff,
              32'h0003_ffff, 32'h0000_1f00, 32'hffff_ffff);
    for (int i = 0; i < 6; i++) push_step(-16'sd32768, -16'sd32768);
    push_step(16'sd32767, -16'sd32768);
    push_step(16'sd32767, 16'sd32767);
    drain();
    write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_ffff,
              32'h0000_ffff, 32'h0000_00ff, 32'h0000_00ff);
    for (int i = 0; i < 6; i++) push_step(16'sd32767, 16'sd32767);
    push_step(-16'sd32768, 16'sd32767);
    drain();

    // long receiver stall while steps keep coming: the block must back up
    push_random(20);
    hold_off = 3000;
    drain();

    // random phases with random settings
    for (int ph = 0; ph < 8; ph++) begin
      write_all($urandom, $urandom, $urandom,
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 600),
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100),
                $urandom, $urandom);
      if (ph == 7) quiet = 1'b1;
      push_random(180);
      drain();
    end

    repeat (400) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("testbench: errors");
    $finish;
  end

endmodule
